// File: rtl/core/sfrr_pkg.sv
// ----------------------------------------------------------------------------
// sfrr_pkg: shared types and constants of the serial frame receiver
// Holds the item structs, the command codes that pass from the front to the
// back, the frame header codes and the frame kind codes.
// ----------------------------------------------------------------------------
package sfrr_pkg;

  localparam int unsigned FILL_W    = 10;
  localparam int unsigned LEN_W     = 10;
  localparam int unsigned TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] HDR_SYNC   = 8'h0F;
  localparam logic [7:0] HDR_STATUS = 8'hF0;
  localparam logic [7:0] HDR_DREAD  = 8'h55;
  localparam logic [7:0] HDR_DWRITE = 8'h5A;
  localparam logic [7:0] HDR_BREAD  = 8'hA5;
  localparam logic [7:0] HDR_BWRITE = 8'hAA;

  localparam logic [2:0] KIND_SYNC   = 3'd0;
  localparam logic [2:0] KIND_STATUS = 3'd1;
  localparam logic [2:0] KIND_DREAD  = 3'd2;
  localparam logic [2:0] KIND_DWRITE = 3'd3;
  localparam logic [2:0] KIND_BREAD  = 3'd4;
  localparam logic [2:0] KIND_BWRITE = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic              frame_ok;
    logic [2:0]        frame_kind;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  dropped_bytes;
    logic              overflow;
    logic              timeout_flag;
    logic [7:0]        read_data;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_TICK,
    CMD_READ,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill_count;
    logic              timed_out;
  } status_t;

endpackage

// File: rtl/core/sfrr_stream_if.sv
// ----------------------------------------------------------------------------
// sfrr_stream_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface sfrr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/screen_frame_receiver_resync.sv
// Serial frame receiver with header and checksum resync. Each input beat is
// a received byte, a time tick or a read of the byte store, and gives exactly
// one result beat. A two-entry command queue takes beats while the engine is
// busy or a result waits. A received byte that does not overflow the store
// then starts a scan through the single store read port: a header check,
// then a checksum pass (one byte a cycle), and a drop of the head byte when
// the header is unknown or the checksum fails, repeated until the scan
// settles. There is no clearing pass after reset; the timeout register
// resets to 100 ticks.
// ----------------------------------------------------------------------------
// screen_frame_receiver_resync: top level
// Joins the input front end, the resync engine and the configuration port.
// ----------------------------------------------------------------------------
module screen_frame_receiver_resync #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfrr_pkg::TIMEOUT_W-1:0] cfg_wdata_i,
  sfrr_stream_if.sink                    in_i,
  sfrr_stream_if.source                  out_o
);

  sfrr_stream_if #(.T(sfrr_pkg::cmd_t)) cmd_ch ();
  sfrr_pkg::status_t status;

  sfrr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_o  (cmd_ch)
  );

  sfrr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_ch),
    .out_o       (out_o),
    .status_o    (status)
  );

  a_fill_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, status.fill_count} < (sfrr_pkg::FILL_W+1)'(BUFFER_DEPTH))
    else $error("fill count reached store depth");

  a_timeout_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.timed_out |-> status.fill_count == '0)
    else $error("store not empty while timed out");

  a_frame_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.frame_ok) |->
      (out_o.payload.frame_length >= 10'd3 && !out_o.payload.overflow
       && status.fill_count == '0))
    else $error("accepted frame with bad length or overflow");

endmodule

// File: rtl/core/sfrr_front.sv
// ----------------------------------------------------------------------------
// sfrr_front: input acceptance and command queue
// Decodes each input beat into a command and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module sfrr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfrr_stream_if.sink    in_i,
  sfrr_stream_if.source  cmd_o
);

  sfrr_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  sfrr_pkg::cmd_t cmd_new;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_new.data_byte  = in_i.payload.data_byte;
    cmd_new.read_index = in_i.payload.read_index;
    unique case (in_i.payload.mode)
      sfrr_pkg::MODE_BYTE: cmd_new.kind = sfrr_pkg::CMD_BYTE;
      sfrr_pkg::MODE_TICK: cmd_new.kind = sfrr_pkg::CMD_TICK;
      sfrr_pkg::MODE_READ: cmd_new.kind = sfrr_pkg::CMD_READ;
      default:             cmd_new.kind = sfrr_pkg::CMD_NOP;
    endcase
  end

  assign in_i.ready    = (count_q != 2'd2);
  assign push          = in_i.valid && in_i.ready;
  assign cmd_o.valid   = (count_q != 2'd0);
  assign cmd_o.payload = entry_q[rd_ptr_q];
  assign pop           = cmd_o.valid && cmd_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

// File: rtl/core/sfrr_back.sv
// ----------------------------------------------------------------------------
// sfrr_back: frame store and resync engine
// Executes one command at a time against the byte store: appends bytes,
// scans header and checksum, drops bytes on resync, counts ticks and serves
// reads. The store is a ring with a base pointer; a drop advances the base.
// ----------------------------------------------------------------------------
module sfrr_back #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfrr_pkg::TIMEOUT_W-1:0]    cfg_wdata_i,
  sfrr_stream_if.sink                       cmd_i,
  sfrr_stream_if.source                     out_o,
  output sfrr_pkg::status_t                 status_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW:0] DEPTH_A = (AW+1)'(BUFFER_DEPTH);
  localparam logic [sfrr_pkg::FILL_W:0] DEPTH_F = (sfrr_pkg::FILL_W+1)'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_CHECK, ST_HDR0, ST_HDR1,
    ST_SUM, ST_DROP, ST_DROP_W, ST_DONE
  } state_e;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                        input logic [AW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= DEPTH_A) s = s - DEPTH_A;
    return s[AW-1:0];
  endfunction

  logic [7:0]                     mem_q [BUFFER_DEPTH];
  logic [7:0]                     rdata_q;
  logic [AW-1:0]                  rd_addr;
  logic                           we;
  logic [AW-1:0]                  wr_addr;
  logic [7:0]                     wr_data;

  state_e                         state_q;
  logic [AW-1:0]                  base_q;
  logic [sfrr_pkg::FILL_W-1:0]    fill_q;
  logic [sfrr_pkg::TIMEOUT_W-1:0] idle_q;
  logic                           timed_out_q;
  logic [sfrr_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [7:0]                     hdr_q;
  logic [sfrr_pkg::LEN_W-1:0]     len_q;
  logic [2:0]                     kind_q;
  logic [sfrr_pkg::LEN_W-1:0]     idx_q;
  logic [7:0]                     sum_q;
  logic                           ok_q;
  logic [2:0]                     res_kind_q;
  logic [sfrr_pkg::LEN_W-1:0]     flen_q;
  logic [sfrr_pkg::LEN_W-1:0]     drop_q;
  logic                           ovf_q;
  logic [7:0]                     rd_q;
  logic                           out_valid_q;
  sfrr_pkg::out_item_t            out_q;

  logic                           take;
  logic                           read_in_range;
  logic [sfrr_pkg::FILL_W:0]      fill_inc;
  logic [sfrr_pkg::TIMEOUT_W-1:0] limit;
  logic [sfrr_pkg::TIMEOUT_W:0]   idle_inc;
  logic [sfrr_pkg::LEN_W-1:0]     hdr_len;
  logic [2:0]                     hdr_kind;

  assign take          = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready   = (state_q == ST_IDLE) && !out_valid_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign status_o.fill_count = fill_q;
  assign status_o.timed_out  = timed_out_q;

  assign read_in_range = {2'b00, cmd_i.payload.read_index} < (sfrr_pkg::FILL_W+1)'(BUFFER_DEPTH);
  assign fill_inc      = {1'b0, fill_q} + 1'b1;
  assign limit         = (timeout_q == '0) ? sfrr_pkg::TIMEOUT_W'(1) : timeout_q;
  assign idle_inc      = {1'b0, idle_q} + 1'b1;

  // Header decode: n is the second byte, now in the read register
  always_comb begin
    unique case (hdr_q)
      sfrr_pkg::HDR_SYNC: begin
        hdr_kind = sfrr_pkg::KIND_SYNC;   hdr_len = 10'd5;
      end
      sfrr_pkg::HDR_STATUS: begin
        hdr_kind = sfrr_pkg::KIND_STATUS; hdr_len = 10'd3;
      end
      sfrr_pkg::HDR_DREAD: begin
        hdr_kind = sfrr_pkg::KIND_DREAD;  hdr_len = {1'b0, rdata_q, 1'b0} + 10'd3;
      end
      sfrr_pkg::HDR_DWRITE: begin
        hdr_kind = sfrr_pkg::KIND_DWRITE;
        hdr_len  = {1'b0, rdata_q, 1'b0} + {2'b00, rdata_q} + 10'd3;
      end
      sfrr_pkg::HDR_BREAD: begin
        hdr_kind = sfrr_pkg::KIND_BREAD;  hdr_len = 10'd5;
      end
      sfrr_pkg::HDR_BWRITE: begin
        hdr_kind = sfrr_pkg::KIND_BWRITE; hdr_len = {2'b00, rdata_q} + 10'd5;
      end
      default: begin
        hdr_kind = sfrr_pkg::KIND_SYNC;   hdr_len = '0;
      end
    endcase
  end

  always_comb begin
    rd_addr = base_q;
    we      = 1'b0;
    wr_addr = base_q;
    wr_data = rdata_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && cmd_i.payload.kind == sfrr_pkg::CMD_BYTE) begin
          we      = 1'b1;
          wr_addr = phys(base_q, fill_q[AW-1:0]);
          wr_data = cmd_i.payload.data_byte;
        end
        rd_addr = phys(base_q, AW'(cmd_i.payload.read_index));
      end
      ST_HDR0:   rd_addr = phys(base_q, AW'(1));
      ST_SUM:    rd_addr = phys(base_q, idx_q[AW-1:0] + AW'(1));
      // Last slot keeps its byte across a drop: fetch it to refill the old head
      ST_DROP:   rd_addr = phys(base_q, LAST_IDX);
      ST_DROP_W: we = 1'b1;
      default:   rd_addr = base_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      fill_q      <= '0;
      idle_q      <= '0;
      timed_out_q <= 1'b1;
      timeout_q   <= sfrr_pkg::TIMEOUT_RESET;
      out_valid_q <= 1'b0;
      hdr_q       <= '0;
      len_q       <= '0;
      kind_q      <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      ok_q        <= 1'b0;
      res_kind_q  <= '0;
      flen_q      <= '0;
      drop_q      <= '0;
      ovf_q       <= 1'b0;
      rd_q        <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            ok_q       <= 1'b0;
            res_kind_q <= '0;
            flen_q     <= '0;
            drop_q     <= '0;
            ovf_q      <= 1'b0;
            rd_q       <= '0;
            unique case (cmd_i.payload.kind)
              sfrr_pkg::CMD_BYTE: begin
                idle_q      <= '0;
                timed_out_q <= 1'b0;
                if (fill_inc == DEPTH_F) begin
                  fill_q  <= '0;
                  ovf_q   <= 1'b1;
                  state_q <= ST_DONE;
                end else begin
                  fill_q  <= fill_inc[sfrr_pkg::FILL_W-1:0];
                  state_q <= ST_CHECK;
                end
              end
              sfrr_pkg::CMD_TICK: begin
                if (idle_inc >= {1'b0, limit}) begin
                  idle_q      <= '0;
                  timed_out_q <= 1'b1;
                  fill_q      <= '0;
                end else begin
                  idle_q <= idle_inc[sfrr_pkg::TIMEOUT_W-1:0];
                  if (timed_out_q) fill_q <= '0;
                end
                state_q <= ST_DONE;
              end
              sfrr_pkg::CMD_READ: begin
                state_q <= read_in_range ? ST_RD_WAIT : ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          rd_q    <= rdata_q;
          state_q <= ST_DONE;
        end
        ST_CHECK: begin
          state_q <= (fill_q > 10'd1) ? ST_HDR0 : ST_DONE;
        end
        ST_HDR0: begin
          hdr_q   <= rdata_q;
          state_q <= ST_HDR1;
        end
        ST_HDR1: begin
          priority if (hdr_len == '0) begin
            state_q <= ST_DROP;
          end else if (fill_q < hdr_len) begin
            state_q <= ST_DONE;
          end else begin
            len_q   <= hdr_len;
            kind_q  <= hdr_kind;
            idx_q   <= '0;
            sum_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (idx_q == len_q - 10'd1) begin
            if (sum_q == rdata_q) begin
              ok_q       <= 1'b1;
              res_kind_q <= kind_q;
              flen_q     <= len_q;
              fill_q     <= '0;
              state_q    <= ST_DONE;
            end else begin
              state_q <= ST_DROP;
            end
          end else begin
            sum_q <= sum_q ^ rdata_q;
            idx_q <= idx_q + 10'd1;
          end
        end
        ST_DROP: state_q <= ST_DROP_W;
        ST_DROP_W: begin
          base_q  <= phys(base_q, AW'(1));
          fill_q  <= fill_q - 10'd1;
          drop_q  <= drop_q + 10'd1;
          state_q <= ST_CHECK;
        end
        ST_DONE: begin
          out_q.frame_ok      <= ok_q;
          out_q.frame_kind    <= res_kind_q;
          out_q.frame_length  <= flen_q;
          out_q.dropped_bytes <= drop_q;
          out_q.overflow      <= ovf_q;
          out_q.timeout_flag  <= timed_out_q;
          out_q.read_data     <= rd_q;
          out_valid_q         <= 1'b1;
          state_q             <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: serial frame receiver with header and checksum resync
// Feeds received bytes, ticks, store reads and the unused mode through the
// input channel and checks every result beat against a local model of the
// byte store, the fill count, the idle tick counter and the timeout state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DEPTH = 512;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sfrr_pkg::TIMEOUT_W-1:0] cfg_wdata_i;

  sfrr_stream_if #(.T(sfrr_pkg::in_item_t))  in_if ();
  sfrr_stream_if #(.T(sfrr_pkg::out_item_t)) out_if ();

  screen_frame_receiver_resync #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Model state
  logic [7:0]                     rx_bytes [DEPTH];
  bit                             rx_written [DEPTH];
  int unsigned                    fill;
  int unsigned                    idle_ticks;
  bit                             timed_out;
  logic [sfrr_pkg::TIMEOUT_W-1:0] timeout_ticks;

  sfrr_pkg::out_item_t pending_results [$];
  int unsigned         mismatches;
  int unsigned         items_sent;
  bit                  gaps_on;
  bit                  stalls_on;
  int unsigned         holdoff_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void drop_head();
    for (int i = 0; i < DEPTH - 1; i++) begin
      rx_bytes[i]   = rx_bytes[i+1];
      rx_written[i] = rx_written[i+1];
    end
    if (fill > 0) fill--;
  endfunction

  function automatic sfrr_pkg::out_item_t receive_step(sfrr_pkg::in_item_t it);
    sfrr_pkg::out_item_t r;
    int unsigned         len;
    int unsigned         n;
    logic [2:0]          kind;
    logic [7:0]          sum;
    int unsigned         limit;
    r = '0;
    case (it.mode)
      sfrr_pkg::MODE_BYTE: begin
        if (fill < DEPTH) begin
          rx_bytes[fill]   = it.data_byte;
          rx_written[fill] = 1'b1;
        end
        fill++;
        if (fill >= DEPTH) begin
          fill = 0;
          r.overflow = 1'b1;
        end
        idle_ticks = 0;
        timed_out  = 1'b0;
        while (fill > 1) begin
          n = rx_bytes[1];
          case (rx_bytes[0])
            sfrr_pkg::HDR_SYNC:   begin kind = sfrr_pkg::KIND_SYNC;   len = 5;         end
            sfrr_pkg::HDR_STATUS: begin kind = sfrr_pkg::KIND_STATUS; len = 3;         end
            sfrr_pkg::HDR_DREAD:  begin kind = sfrr_pkg::KIND_DREAD;  len = 2 * n + 3; end
            sfrr_pkg::HDR_DWRITE: begin kind = sfrr_pkg::KIND_DWRITE; len = 3 * n + 3; end
            sfrr_pkg::HDR_BREAD:  begin kind = sfrr_pkg::KIND_BREAD;  len = 5;         end
            sfrr_pkg::HDR_BWRITE: begin kind = sfrr_pkg::KIND_BWRITE; len = n + 5;     end
            default:              begin kind = sfrr_pkg::KIND_SYNC;   len = 0;         end
          endcase
          if (len == 0) begin
            drop_head();
            r.dropped_bytes++;
            continue;
          end
          if (fill < len) break;
          sum = '0;
          for (int i = 0; i < len - 1; i++) sum ^= rx_bytes[i];
          if (sum != rx_bytes[len-1]) begin
            drop_head();
            r.dropped_bytes++;
            continue;
          end
          r.frame_ok     = 1'b1;
          r.frame_kind   = kind;
          r.frame_length = len[sfrr_pkg::LEN_W-1:0];
          fill = 0;
          break;
        end
      end
      sfrr_pkg::MODE_TICK: begin
        limit = (timeout_ticks == 0) ? 1 : timeout_ticks;
        idle_ticks++;
        if (idle_ticks >= limit) begin
          idle_ticks = 0;
          timed_out  = 1'b1;
        end
        if (timed_out) fill = 0;
      end
      sfrr_pkg::MODE_READ: r.read_data = rx_bytes[it.read_index];
      default: ;
    endcase
    r.timeout_flag = timed_out;
    return r;
  endfunction

  // Send one beat; valid stays high when the next beat follows at once
  task automatic send_item(sfrr_pkg::in_item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(receive_step(it));
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    sfrr_pkg::in_item_t it;
    it = '{mode: sfrr_pkg::MODE_BYTE, data_byte: b, read_index: 9'($urandom)};
    send_item(it);
  endtask

  task automatic send_tick();
    sfrr_pkg::in_item_t it;
    it = '{mode: sfrr_pkg::MODE_TICK, data_byte: 8'($urandom), read_index: 9'($urandom)};
    send_item(it);
  endtask

  // Read only entries that have been written
  task automatic send_read();
    sfrr_pkg::in_item_t it;
    int unsigned        idx;
    idx = $urandom_range(0, DEPTH - 1);
    for (int i = 0; i < DEPTH && !rx_written[idx]; i++) idx = (idx + 1) % DEPTH;
    if (!rx_written[idx]) return;
    it = '{mode: sfrr_pkg::MODE_READ, data_byte: 8'($urandom), read_index: idx[8:0]};
    send_item(it);
  endtask

  task automatic send_unused();
    sfrr_pkg::in_item_t it;
    it = '{mode: sfrr_pkg::MODE_UNUSED, data_byte: 8'($urandom),
           read_index: 9'($urandom)};
    send_item(it);
  endtask

  // Frame with payload count n; corrupt flips the checksum
  task automatic send_frame(logic [7:0] hdr, logic [7:0] n, bit corrupt);
    int unsigned len;
    logic [7:0]  sum;
    logic [7:0]  b;
    case (hdr)
      sfrr_pkg::HDR_SYNC, sfrr_pkg::HDR_BREAD: len = 5;
      sfrr_pkg::HDR_STATUS:                    len = 3;
      sfrr_pkg::HDR_DREAD:                     len = 2 * n + 3;
      sfrr_pkg::HDR_DWRITE:                    len = 3 * n + 3;
      default:                                 len = n + 5;
    endcase
    sum = hdr;
    send_byte(hdr);
    for (int i = 1; i < len - 1; i++) begin
      b = (i == 1) ? n : 8'($urandom);
      sum ^= b;
      send_byte(b);
    end
    send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // Lower valid, wait for every result, then let the engine settle
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [sfrr_pkg::TIMEOUT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_ticks = v;
  endtask

  task automatic pick_header(output logic [7:0] hdr);
    case ($urandom_range(0, 5))
      0: hdr = sfrr_pkg::HDR_SYNC;
      1: hdr = sfrr_pkg::HDR_STATUS;
      2: hdr = sfrr_pkg::HDR_DREAD;
      3: hdr = sfrr_pkg::HDR_DWRITE;
      4: hdr = sfrr_pkg::HDR_BREAD;
      default: hdr = sfrr_pkg::HDR_BWRITE;
    endcase
  endtask

  task automatic test_directed();
    write_timeout(16'd3);
    send_tick();
    send_frame(sfrr_pkg::HDR_SYNC, 8'h00, 1'b0);
    send_frame(sfrr_pkg::HDR_STATUS, 8'hFF, 1'b0);
    send_frame(sfrr_pkg::HDR_DREAD, 8'd1, 1'b0);
    send_read();
    send_byte(8'h00);             // unknown header, dropped
    send_frame(sfrr_pkg::HDR_BREAD, 8'h12, 1'b1);
    send_tick();
    send_tick();
    send_tick();                  // times out, store flushed
    send_unused();
    send_frame(sfrr_pkg::HDR_BWRITE, 8'd0, 1'b0);
    drain();
  endtask

  // Fill the store behind an unreachable frame length and overflow it,
  // with the receiver held off so the input stalls
  task automatic test_overflow();
    holdoff_cycles = 400;
    send_byte(sfrr_pkg::HDR_DWRITE);
    send_byte(8'hFF);
    for (int i = 2; i < DEPTH; i++) send_byte(8'($urandom));
    drain();
  endtask

  task automatic test_random_phase(logic [sfrr_pkg::TIMEOUT_W-1:0] tmo,
                                   int unsigned items);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  hdr;
    write_timeout(tmo);
    target = items_sent + items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick_header(hdr);
        send_frame(hdr, 8'($urandom_range(0, 6)), $urandom_range(0, 6) == 0);
      end else if (pick < 70) begin
        send_byte(8'($urandom));
      end else if (pick < 82) begin
        send_tick();
      end else if (pick < 95) begin
        send_read();
      end else begin
        send_unused();
      end
    end
    drain();
  endtask

  initial begin : receiver
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        stall = stalls_on ? $urandom_range(0, 5) : 0;
      if (holdoff_cycles > 0) holdoff_cycles--;
      else if (stall > 0) stall--;
      out_if.ready <= (holdoff_cycles == 0) && (stall == 0);
    end
  end

  initial begin : result_check
    sfrr_pkg::out_item_t exp_r;
    sfrr_pkg::out_item_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.frame_ok !== exp_r.frame_ok) begin
            $error("frame_ok exp %0d got %0d", exp_r.frame_ok, got.frame_ok);
            mismatches++;
          end
          if (got.frame_kind !== exp_r.frame_kind) begin
            $error("frame_kind exp %0d got %0d", exp_r.frame_kind, got.frame_kind);
            mismatches++;
          end
          if (got.frame_length !== exp_r.frame_length) begin
            $error("frame_length exp %0d got %0d", exp_r.frame_length, got.frame_length);
            mismatches++;
          end
          if (got.dropped_bytes !== exp_r.dropped_bytes) begin
            $error("dropped_bytes exp %0d got %0d", exp_r.dropped_bytes, got.dropped_bytes);
            mismatches++;
          end
          if (got.overflow !== exp_r.overflow) begin
            $error("overflow exp %0d got %0d", exp_r.overflow, got.overflow);
            mismatches++;
          end
          if (got.timeout_flag !== exp_r.timeout_flag) begin
            $error("timeout_flag exp %0d got %0d", exp_r.timeout_flag, got.timeout_flag);
            mismatches++;
          end
          if (got.read_data !== exp_r.read_data) begin
            $error("read_data exp %0h got %0h", exp_r.read_data, got.read_data);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : run
    mismatches     = 0;
    items_sent     = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    holdoff_cycles = 0;
    fill           = 0;
    idle_ticks     = 0;
    timed_out      = 1'b1;
    timeout_ticks  = sfrr_pkg::TIMEOUT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      rx_bytes[i]   = '0;
      rx_written[i] = 1'b0;
    end
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_overflow();
    test_random_phase(16'd1, 100);
    test_random_phase(16'hFFFF, 100);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_phase(16'($urandom_range(2, 12)), 120);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_random_phase(sfrr_pkg::TIMEOUT_RESET, 100);

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sfrr_pkg.sv
rtl/core/sfrr_stream_if.sv
rtl/core/sfrr_front.sv
rtl/core/sfrr_back.sv
rtl/core/screen_frame_receiver_resync.sv
tb/sv/testbench.sv
